>>> hw/rtl/wftd_pkg.sv
// ----------------------------------------------------------------------------
// wftd_pkg
// Shared types, codes and lookup functions for the wall-follow turn decider.
// ----------------------------------------------------------------------------
`default_nettype none

package wftd_pkg;

    localparam int NUM_CASES = 8;

    typedef enum logic [1:0] {
        CMD_FWD   = 2'd0,
        CMD_SLOW  = 2'd1,
        CMD_LEFT  = 2'd2,
        CMD_RIGHT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_TURNED = 2'd1,
        PH_SETTLE = 2'd2
    } t_phase;

    // configuration register indexes
    localparam logic [1:0] CFG_SIDE_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_FRONT_LIMIT = 2'd1;
    localparam logic [1:0] CFG_LEFT_FLOOR  = 2'd2;
    localparam logic [1:0] CFG_LEFT_MARGIN = 2'd3;

    // wall cases with special handling
    localparam logic [2:0] CASE_FWD_POST   = 3'd0;
    localparam logic [2:0] CASE_LEFT_SLOW  = 3'd2;
    localparam logic [2:0] CASE_RIGHT_HOLD0 = 3'd4;
    localparam logic [2:0] CASE_RIGHT_HOLD1 = 3'd5;

    typedef struct packed {
        logic       wr;          // right wall present
        logic       f_lt_limit;  // signed front below front limit
        logic [2:0] wcase;       // wall case
    } t_class;

    // {R,F,L} -> wall case
    function automatic logic [2:0] case_of_bits(input logic [2:0] rfl);
        logic [2:0] c;
        case (rfl)
            3'b000:  c = 3'd6;
            3'b001:  c = 3'd7;
            3'b010:  c = 3'd4;
            3'b011:  c = 3'd5;
            3'b100:  c = 3'd1;
            3'b101:  c = 3'd0;
            3'b110:  c = 3'd3;
            3'b111:  c = 3'd2;
            default: c = 3'd0;
        endcase
        return c;
    endfunction

    function automatic t_cmd cmd_of_case(input logic [2:0] c);
        t_cmd m;
        case (c)
            3'd0, 3'd1: m = CMD_FWD;
            3'd2, 3'd3: m = CMD_LEFT;
            default:    m = CMD_RIGHT;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/wftd_classify.sv
// ----------------------------------------------------------------------------
// wftd_classify
// Range-to-wall-bit compares and wall case lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module wftd_classify (
    input  wire logic signed [10:0] i_left_range,
    input  wire logic signed [10:0] i_right_range,
    input  wire logic signed [10:0] i_front_range,
    input  wire logic [9:0]         i_side_limit,
    input  wire logic [9:0]         i_front_limit,
    output wftd_pkg::t_class        o_cls
);
    import wftd_pkg::*;

    logic wl;
    logic wr;
    logic wf;

    // negative range never counts as a wall
    assign wl = !i_left_range[10]  && (i_left_range[9:0]  < i_side_limit);
    assign wr = !i_right_range[10] && (i_right_range[9:0] < i_side_limit);
    assign wf = !i_front_range[10] && (i_front_range[9:0] < i_front_limit);

    assign o_cls.wr         = wr;
    assign o_cls.f_lt_limit = i_front_range[10] || (i_front_range[9:0] < i_front_limit);
    assign o_cls.wcase      = case_of_bits({wr, wf, wl});

endmodule

`default_nettype wire

>>> hw/rtl/wftd_decide.sv
// ----------------------------------------------------------------------------
// wftd_decide
// Vote counter bank, turn phase sequencer and command selection.
// ----------------------------------------------------------------------------
`default_nettype none

module wftd_decide #(
    parameter int VOTE_MAX = 5
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_step,
    input  wire wftd_pkg::t_class   i_cls,
    input  wire logic signed [10:0] i_front_range,
    input  wire logic [9:0]         i_left_floor,
    input  wire logic [7:0]         i_left_margin,
    output logic                    o_emit,
    output wftd_pkg::t_cmd          o_cmd,
    output logic [2:0]              o_wcase
);
    import wftd_pkg::*;

    localparam int VW = $clog2(VOTE_MAX + 1);
    localparam logic [VW-1:0] VMAX = VW'(VOTE_MAX);
    localparam logic [VW-1:0] HALF = VW'(VOTE_MAX / 2);

    logic [VW-1:0]       r_votes [NUM_CASES];
    logic [VW-1:0]       n_votes [NUM_CASES];
    logic [VW-1:0]       votes_new [NUM_CASES];
    t_phase              r_phase, n_phase;
    logic [VW-1:0]       r_settle, n_settle;
    logic                r_prev_fwd, n_prev_fwd;
    logic                r_pending, n_pending;
    logic [2:0]          r_pend_case, n_pend_case;
    logic signed [10:0]  r_mark, n_mark;

    logic [VW-1:0]       settle_plus;
    logic                settle_done;
    logic                classify;
    logic                lt_mark;
    logic [VW-1:0]       sel_votes;
    logic                at_half;
    logic                at_max;
    logic                slow;
    logic                hold;
    logic                restart;
    t_cmd                case_cmd;
    logic [10:0]         f_adj;
    logic signed [10:0]  f_half;
    logic signed [12:0]  f_less_margin;

    assign settle_plus = (i_cls.wr && (r_settle < VMAX)) ? r_settle + VW'(1) : r_settle;
    assign settle_done = (r_phase == PH_SETTLE) && (settle_plus >= VMAX);
    assign classify    = !r_pending && ((r_phase == PH_IDLE)
                       || ((r_phase == PH_TURNED) && i_cls.f_lt_limit) || settle_done);
    assign lt_mark     = i_front_range < r_mark;

    // saturating vote update; settle completion restarts from an empty bank
    always_comb begin
        logic [VW-1:0] base;
        for (int k = 0; k < NUM_CASES; k++) begin
            base = settle_done ? '0 : r_votes[k];
            if (3'(k) == i_cls.wcase) begin
                votes_new[k] = (base < VMAX) ? base + VW'(1) : VMAX;
            end else begin
                votes_new[k] = (base != '0) ? base - VW'(1) : '0;
            end
        end
    end

    assign sel_votes = votes_new[i_cls.wcase];
    assign at_half   = sel_votes == HALF;
    assign at_max    = sel_votes >= VMAX;
    assign case_cmd  = cmd_of_case(i_cls.wcase);
    assign slow      = at_half && (i_cls.wcase[2] || (i_cls.wcase == CASE_LEFT_SLOW));
    assign hold      = at_max && ((i_cls.wcase == CASE_RIGHT_HOLD0)
                    || (i_cls.wcase == CASE_RIGHT_HOLD1)) && !lt_mark;

    // front / 2 rounded toward zero
    assign f_adj  = i_front_range + {10'b0, i_front_range[10]};
    assign f_half = $signed(f_adj) >>> 1;

    assign f_less_margin = {{2{i_front_range[10]}}, i_front_range} - {5'b0, i_left_margin};
    assign restart       = f_less_margin >= $signed({3'b0, i_left_floor});

    // next state
    always_comb begin
        n_votes     = r_votes;
        n_phase     = r_phase;
        n_settle    = r_settle;
        n_prev_fwd  = r_prev_fwd;
        n_pending   = r_pending;
        n_pend_case = r_pend_case;
        n_mark      = r_mark;
        if (r_pending) begin
            if (lt_mark) begin
                n_pending = 1'b0;
            end
        end else begin
            case (r_phase)
                PH_TURNED: begin
                    if (i_cls.f_lt_limit) begin
                        n_settle = '0;
                        n_phase  = PH_IDLE;
                    end else begin
                        // settling counts this same sample
                        n_settle   = {{(VW-1){1'b0}}, i_cls.wr};
                        n_phase    = PH_SETTLE;
                        n_prev_fwd = 1'b1;
                    end
                end
                PH_SETTLE: begin
                    if (settle_done) begin
                        n_settle = '0;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_settle = settle_plus;
                    end
                end
                PH_IDLE: begin
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
            if (classify) begin
                n_votes = votes_new;
                if (slow) begin
                    n_prev_fwd = 1'b0;
                    if (i_cls.wcase[2]) begin
                        n_mark = f_half;
                    end else if (restart) begin
                        n_votes[CASE_LEFT_SLOW] = '0;
                    end
                end
                if (at_max) begin
                    n_prev_fwd = case_cmd == CMD_FWD;
                    if (case_cmd != CMD_FWD) begin
                        n_phase = PH_TURNED;
                        if (hold) begin
                            n_pending   = 1'b1;
                            n_pend_case = i_cls.wcase;
                        end
                    end
                end
            end
        end
    end

    // command output
    always_comb begin
        o_emit  = 1'b0;
        o_cmd   = CMD_FWD;
        o_wcase = CASE_FWD_POST;
        if (r_pending) begin
            o_emit  = lt_mark;
            o_cmd   = CMD_RIGHT;
            o_wcase = r_pend_case;
        end else if ((r_phase == PH_TURNED) && !i_cls.f_lt_limit) begin
            o_emit = 1'b1;
        end else if (classify) begin
            o_wcase = i_cls.wcase;
            if (slow) begin
                o_emit = 1'b1;
                o_cmd  = CMD_SLOW;
            end else if (at_max) begin
                o_cmd  = case_cmd;
                o_emit = (case_cmd == CMD_FWD) ? !r_prev_fwd : !hold;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_CASES; k++) begin
                r_votes[k] <= '0;
            end
            r_phase     <= PH_IDLE;
            r_settle    <= '0;
            r_prev_fwd  <= 1'b0;
            r_pending   <= 1'b0;
            r_pend_case <= '0;
            r_mark      <= '0;
        end else if (i_step) begin
            r_votes     <= n_votes;
            r_phase     <= n_phase;
            r_settle    <= n_settle;
            r_prev_fwd  <= n_prev_fwd;
            r_pending   <= n_pending;
            r_pend_case <= n_pend_case;
            r_mark      <= n_mark;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wall_follow_turn_decider_core.sv
// ----------------------------------------------------------------------------
// wall_follow_turn_decider_core
// Sonar range samples in, drive commands out, with vote-based wall tracking.
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  s_axis    in         tvalid/tready       left, right, front range
//  m_axis    out        tvalid/tready       drive command, wall case, tlast
//  cfg       in         we (no wait)        four limit registers
//
//  A sample is held in the input register, then the decision logic updates
//  all state and loads the result register, one sample per cycle sustained
//  unless a waiting result is not taken. Samples that cause no command leave no result.
//  Synchronous active-low reset clears all votes and the turn sequencer.
//  A stalled result register stalls the input register, which stalls s_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module wall_follow_turn_decider_core #(
    parameter int VOTE_MAX = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [39:0] i_s_tdata,    // left_range, right_range, front_range
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,    // drive_command, wall_case
    output logic             o_m_tlast,    // last_of_run
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [9:0]  i_cfg_wdata
);
    import wftd_pkg::*;

    logic               r_in_valid;
    logic signed [10:0] r_left, r_right, r_front;
    logic               r_out_valid;
    t_cmd               r_out_cmd;
    logic [2:0]         r_out_case;
    logic [9:0]         r_side_limit, r_front_limit, r_left_floor;
    logic [7:0]         r_left_margin;

    logic   out_free;
    logic   step;
    t_class cls;
    logic   emit;
    t_cmd   emit_cmd;
    logic [2:0] emit_case;

    assign out_free   = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && out_free;
    assign o_s_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_limit  <= 10'd300;
            r_front_limit <= 10'd300;
            r_left_floor  <= 10'd100;
            r_left_margin <= 8'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SIDE_LIMIT:  r_side_limit  <= i_cfg_wdata;
                CFG_FRONT_LIMIT: r_front_limit <= i_cfg_wdata;
                CFG_LEFT_FLOOR:  r_left_floor  <= i_cfg_wdata;
                CFG_LEFT_MARGIN: r_left_margin <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_left  <= i_s_tdata[10:0];
            r_right <= i_s_tdata[21:11];
            r_front <= i_s_tdata[32:22];
        end
    end

    wftd_classify u_classify (
        .i_left_range  (r_left),
        .i_right_range (r_right),
        .i_front_range (r_front),
        .i_side_limit  (r_side_limit),
        .i_front_limit (r_front_limit),
        .o_cls         (cls)
    );

    wftd_decide #(
        .VOTE_MAX (VOTE_MAX)
    ) u_decide (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_cls         (cls),
        .i_front_range (r_front),
        .i_left_floor  (r_left_floor),
        .i_left_margin (r_left_margin),
        .o_emit        (emit),
        .o_cmd         (emit_cmd),
        .o_wcase       (emit_case)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out_cmd  <= emit_cmd;
            r_out_case <= emit_case;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_case, r_out_cmd};
    // each sample causes at most one command
    assign o_m_tlast  = 1'b1;

endmodule

`default_nettype wire

>>> test/wall_follow_turn_decider_checker.sv
// ----------------------------------------------------------------------------
// wall_follow_turn_decider_checker
// Watches the sample, command and register channels of the turn decider,
// predicts the drive commands of every accepted sample and compares them,
// field by field and in order, with the commands the block hands out.
// ----------------------------------------------------------------------------
module wall_follow_turn_decider_checker #(
    parameter int VOTE_MAX = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [39:0] i_s_tdata,    // left_range, right_range, front_range
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [7:0]  i_m_tdata,    // drive_command, wall_case
    input  wire logic        i_m_tlast,    // last_of_run
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [9:0]  i_cfg_wdata,
    output int               o_fail_count,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import wftd_pkg::*;

    localparam int HALF_VOTES = VOTE_MAX / 2;
    // wall case per {R,F,L}, entry 0 in the lowest bits
    localparam logic [23:0] CASE_BY_RFL =
        {3'd2, 3'd3, 3'd0, 3'd1, 3'd5, 3'd4, 3'd7, 3'd6};

    typedef struct packed {
        t_cmd       cmd;
        logic [2:0] wcase;
        logic       last;
    } t_drive_result;

    t_drive_result   expected_cmds[$];
    int              fail_count = 0;

    logic [9:0]        side_limit;
    logic [9:0]        front_limit;
    logic [9:0]        left_floor;
    logic [7:0]        left_margin;
    logic [3:0]        votes [NUM_CASES];
    t_phase            phase;
    logic [3:0]        settle;
    logic              prev_fwd;
    logic              hold_right;
    logic [2:0]        hold_case;
    logic signed [10:0] front_mark;

    task automatic expect_cmd(input t_cmd cmd, input logic [2:0] wcase);
        t_drive_result res;
        res.cmd = cmd;
        res.wcase = wcase;
        res.last = 1'b1;
        expected_cmds.push_back(res);
    endtask

    task automatic predict_drive(input logic [39:0] data);
        logic signed [10:0] l, r, f;
        int   li, ri, fi, half_front;
        logic wl, wr, wf;
        logic [2:0] c;
        t_cmd chosen;
        l = data[10:0];
        r = data[21:11];
        f = data[32:22];
        li = l;
        ri = r;
        fi = f;
        wl = (li >= 0) && (li < int'(side_limit));
        wr = (ri >= 0) && (ri < int'(side_limit));
        wf = (fi >= 0) && (fi < int'(front_limit));

        // a held right turn only looks at the front range
        if (hold_right) begin
            if (fi < int'(front_mark)) begin
                hold_right = 1'b0;
                expect_cmd(CMD_RIGHT, hold_case);
            end
            return;
        end

        if (phase == PH_TURNED) begin
            settle = '0;
            if (fi < int'(front_limit)) begin
                phase = PH_IDLE;
            end else begin
                expect_cmd(CMD_FWD, CASE_FWD_POST);
                prev_fwd = 1'b1;
                phase = PH_SETTLE;
            end
        end

        if (phase == PH_SETTLE) begin
            if (wr && settle < VOTE_MAX) settle = settle + 1'b1;
            if (settle >= VOTE_MAX) begin
                settle = '0;
                phase = PH_IDLE;
                for (int k = 0; k < NUM_CASES; k++) votes[k] = '0;
            end else begin
                return;
            end
        end

        c = CASE_BY_RFL[int'({wr, wf, wl}) * 3 +: 3];
        for (int k = 0; k < NUM_CASES; k++) begin
            if (k == c) begin
                if (votes[k] < VOTE_MAX) votes[k] = votes[k] + 1'b1;
            end else if (votes[k] > 0) begin
                votes[k] = votes[k] - 1'b1;
            end
        end

        if (votes[c] == HALF_VOTES) begin
            if (c >= 3'd4) begin
                half_front = fi / 2;
                front_mark = half_front[10:0];
                prev_fwd = 1'b0;
                expect_cmd(CMD_SLOW, c);
            end else if (c == CASE_LEFT_SLOW) begin
                // restart the left vote unless the wall ahead is already close
                if (!(fi - int'(left_margin) < int'(left_floor))) votes[c] = '0;
                prev_fwd = 1'b0;
                expect_cmd(CMD_SLOW, c);
            end
        end

        if (votes[c] >= VOTE_MAX) begin
            chosen = (c >= 3'd4) ? CMD_RIGHT : (c >= 3'd2) ? CMD_LEFT : CMD_FWD;
            if (chosen == CMD_FWD) begin
                if (!prev_fwd) expect_cmd(CMD_FWD, c);
            end else begin
                phase = PH_TURNED;
                if (chosen == CMD_RIGHT && (c == CASE_RIGHT_HOLD0 || c == CASE_RIGHT_HOLD1)
                    && !(fi < int'(front_mark))) begin
                    hold_right = 1'b1;
                    hold_case = c;
                end else begin
                    expect_cmd(chosen, c);
                end
            end
            prev_fwd = (chosen == CMD_FWD);
        end
    endtask

    always @(posedge i_clk) begin
        t_drive_result exp_res;
        if (!i_rst_n) begin
            side_limit = 10'd300;
            front_limit = 10'd300;
            left_floor = 10'd100;
            left_margin = 8'd50;
            for (int k = 0; k < NUM_CASES; k++) votes[k] = '0;
            phase = PH_IDLE;
            settle = '0;
            prev_fwd = 1'b0;
            hold_right = 1'b0;
            hold_case = '0;
            front_mark = '0;
            expected_cmds.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SIDE_LIMIT:  side_limit = i_cfg_wdata;
                    CFG_FRONT_LIMIT: front_limit = i_cfg_wdata;
                    CFG_LEFT_FLOOR:  left_floor = i_cfg_wdata;
                    CFG_LEFT_MARGIN: left_margin = i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) predict_drive(i_s_tdata);
            if (i_m_tvalid && i_m_tready) begin
                if (expected_cmds.size() == 0) begin
                    $error("unexpected command transaction: tdata %h tlast %b",
                           i_m_tdata, i_m_tlast);
                    fail_count++;
                end else begin
                    exp_res = expected_cmds.pop_front();
                    if (i_m_tdata[1:0] !== exp_res.cmd) begin
                        $error("drive_command: expected %0d, actual %0d",
                               exp_res.cmd, i_m_tdata[1:0]);
                        fail_count++;
                    end
                    if (i_m_tdata[4:2] !== exp_res.wcase) begin
                        $error("wall_case: expected %0d, actual %0d",
                               exp_res.wcase, i_m_tdata[4:2]);
                        fail_count++;
                    end
                    if (i_m_tlast !== exp_res.last) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               exp_res.last, i_m_tlast);
                        fail_count++;
                    end
                end
            end
        end
        o_fail_count <= fail_count;
        o_outstanding <= expected_cmds.size();
    end

endmodule

>>> test/wall_follow_turn_decider_core_tb.sv
// ----------------------------------------------------------------------------
// wall_follow_turn_decider_core_tb
// Drives range samples and limit settings into the turn decider, with random
// back-pressure on both streams; a checker module beside the block predicts
// and compares every drive command.
// ----------------------------------------------------------------------------
module wall_follow_turn_decider_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import wftd_pkg::*;

    localparam int VOTE_MAX = 5;
    // {R,F,L} per wall case, case 0 in the lowest bits
    localparam logic [23:0] RFL_BY_CASE =
        {3'b001, 3'b000, 3'b011, 3'b010, 3'b110, 3'b111, 3'b100, 3'b101};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_idx = CFG_SIDE_LIMIT;
    logic [9:0]  cfg_wdata = '0;
    int          fail_count;
    int          outstanding;

    int          send_idle_pct = 18;
    int          recv_idle_pct = 69;
    logic [9:0]  side_lim = 10'd300;
    logic [9:0]  front_lim = 10'd300;

    wall_follow_turn_decider_core #(
        .VOTE_MAX (VOTE_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tlast   (m_tlast),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    wall_follow_turn_decider_checker #(
        .VOTE_MAX (VOTE_MAX)
    ) checker_i (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tlast     (m_tlast),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(negedge clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("wall_follow_turn_decider_core_tb failed");
        $finish;
    end

    // valid stays high after the transaction so back-to-back samples need no toggle
    task automatic send_sample(input logic [10:0] l, input logic [10:0] r,
                               input logic [10:0] f);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'd0, f, r, l};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // wait out every expected command plus the samples still in the pipe
    task automatic drain_pipeline();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [9:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_limits(input logic [9:0] side, input logic [9:0] front,
                                input logic [9:0] floor_v, input logic [7:0] margin);
        write_reg(CFG_SIDE_LIMIT, side);
        write_reg(CFG_FRONT_LIMIT, front);
        write_reg(CFG_LEFT_FLOOR, floor_v);
        write_reg(CFG_LEFT_MARGIN, {2'b00, margin});
        side_lim = side;
        front_lim = front;
    endtask

    function automatic logic [10:0] pick_range(input logic wall, input logic [9:0] limit);
        int v;
        if (wall && limit != 0)
            v = $urandom_range(int'(limit) - 1, 0);
        else if ($urandom_range(1))
            v = -int'($urandom_range(1024, 1));
        else
            v = $urandom_range(1023, int'(limit));
        return v[10:0];
    endfunction

    // mostly steady runs of one wall case so the votes saturate; some raw noise
    task automatic send_random(input int n_items);
        int sent;
        int run_len;
        logic [2:0] wcase;
        logic [2:0] rfl;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                wcase = 3'($urandom_range(7));
                rfl = RFL_BY_CASE[int'(wcase) * 3 +: 3];
                run_len = $urandom_range(VOTE_MAX + 3, 1);
                for (int k = 0; k < run_len; k++) begin
                    send_sample(pick_range(rfl[0], side_lim),
                                pick_range(rfl[2], side_lim),
                                pick_range(rfl[1], front_lim));
                end
                sent += run_len;
            end else begin
                send_sample(11'($urandom()), 11'($urandom()), 11'($urandom()));
                sent++;
            end
        end
    endtask

    task automatic run_phase(input logic [9:0] side, input logic [9:0] front,
                             input logic [9:0] floor_v, input logic [7:0] margin,
                             input int send_pct, input int recv_pct, input int n_items);
        drain_pipeline();
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        apply_limits(side, front, floor_v, margin);
        send_random(n_items);
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        apply_limits(10'd300, 10'd300, 10'd100, 8'd50);

        // field extremes
        send_sample(11'sd1023, 11'sd1023, 11'sd1023);
        send_sample(-11'sd1024, -11'sd1024, -11'sd1024);
        send_sample(11'sd0, 11'sd0, 11'sd0);
        send_sample(-11'sd1, -11'sd1, -11'sd1);
        // all walls: slow with the wall ahead close, then left turn
        repeat (5) send_sample(11'sd50, 11'sd50, 11'sd60);
        // open front after the turn: forward, then settle on the right wall
        send_sample(11'sd500, 11'sd500, 11'sd1000);
        repeat (5) send_sample(-11'sd1, 11'sd100, 11'sd900);
        // front wall only: slow saves half the front, turn held until closer
        repeat (5) send_sample(11'sd500, -11'sd5, 11'sd200);
        send_sample(11'sd500, -11'sd5, 11'sd150);
        send_sample(11'sd500, -11'sd5, 11'sd99);
        // close front after the turn, left vote restarted at slow
        repeat (2) send_sample(11'sd0, 11'sd0, 11'sd200);

        run_phase(10'd300, 10'd300, 10'd100, 8'd50, 18, 69, 360);
        run_phase(10'd1023, 10'd1023, 10'd0, 8'd255, 18, 69, 360);
        run_phase(10'd0, 10'd0, 10'd1023, 8'd0, 69, 18, 150);
        run_phase(10'($urandom_range(1023, 1)), 10'($urandom_range(1023, 1)),
                  10'($urandom_range(1023)), 8'($urandom_range(255)), 69, 18, 450);
        run_phase(10'd400, 10'd700, 10'd200, 8'd120, 0, 0, 450);

        drain_pipeline();
        repeat (6) @(negedge clk);
        if (fail_count == 0)
            $display("wall_follow_turn_decider_core_tb passed");
        else
            $display("wall_follow_turn_decider_core_tb failed");
        $finish;
    end

endmodule
